// ===== hdl/crossfade_group_selector_assert.svh =====
// Assertion helpers for the crossfade group selector.
// Each macro expects i_clk and i_rst_n in the enclosing scope.
`ifndef CROSSFADE_GROUP_SELECTOR_ASSERT_SVH
`define CROSSFADE_GROUP_SELECTOR_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define CGS_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define CGS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cgs_pkg.sv =====
package cgs_pkg;

    localparam int MAX_CHANNELS   = 64;
    localparam int MAX_GROUP_SIZE = 8;
    localparam int SINE_ENTRIES   = 256;

    localparam int CH_W       = $clog2(MAX_CHANNELS);
    localparam int GS_IDX_W   = $clog2(MAX_GROUP_SIZE);
    localparam int SINE_IDX_W = $clog2(SINE_ENTRIES);
    localparam int DIV_NUM_W  = (CH_W > SINE_IDX_W) ? CH_W : SINE_IDX_W;
    localparam int CNT_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int ACC_W      = 24;
    localparam int MIX_W      = 18;
    localparam int STEP_W     = 4;

    localparam logic [GAIN_W-1:0] GAIN_ONE    = 16'h8000;
    localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;

    localparam logic KIND_SELECT = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        CFG_GROUP_SIZE,
        CFG_CHANNEL_COUNT,
        CFG_FADE_SAMPLES
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_CNT,
        ST_DIV,
        ST_MUL,
        ST_ACC,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [CNT_W-1:0]     rem_init;
        logic [DIV_NUM_W-1:0] num;
        logic [STEP_W-1:0]    steps;
        logic [CNT_W-1:0]     divisor;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
        logic [CNT_W-1:0]     rem;
    } t_div_res;

    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [CH_W-1:0]  addr;
        logic [CNT_W-1:0] wdata;
    } t_fade_req;

    typedef struct packed {
        logic                mul_en;
        logic                acc_en;
        logic                clr;
        logic [GS_IDX_W-1:0] idx;
        logic [15:0]         sample;
        logic [GAIN_W-1:0]   gain;
    } t_mix_req;

    typedef logic [GAIN_W-1:0] t_sine_tab [SINE_ENTRIES];

    // Taylor divisors (2i)(2i+1) for i = 1..7
    localparam logic [63:0] TAYLOR_DIV [7] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
    };

    // Quarter sine in Q30, rounded to Q15; evaluated at elaboration only
    function automatic t_sine_tab build_sine();
        t_sine_tab   tab;
        logic [63:0] x;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] r;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            x    = (64'(k) * HALF_PI_Q30) / SINE_ENTRIES;
            sum  = x;
            term = x;
            for (int i = 0; i < 7; i++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / TAYLOR_DIV[i];
                if ((i % 2) == 0) begin
                    sum = (sum >= term) ? sum - term : 64'd0;
                end else begin
                    sum = sum + term;
                end
            end
            r = (sum + 64'd16384) >> 15;
            if (r > 64'(GAIN_ONE)) begin
                r = 64'(GAIN_ONE);
            end
            tab[k] = r[GAIN_W-1:0];
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine();

endpackage

// ===== hdl/cgs_in_if.sv =====
interface cgs_in_if;
    import cgs_pkg::*;

    logic        valid;
    logic        ready;
    logic        kind;
    logic [6:0]  select_group;
    logic [5:0]  channel;
    logic signed [15:0] sample;
    logic        frame_end;

    modport source (output valid, kind, select_group, channel, sample, frame_end,
                    input ready);
    modport sink   (input valid, kind, select_group, channel, sample, frame_end,
                    output ready);
endinterface

// ===== hdl/cgs_out_if.sv =====
interface cgs_out_if;
    import cgs_pkg::*;

    logic        valid;
    logic        ready;
    logic [2:0]  out_channel;
    logic signed [17:0] mixed;
    logic        last;

    modport source (output valid, out_channel, mixed, last, input ready);
    modport sink   (input valid, out_channel, mixed, last, output ready);
endinterface

// ===== hdl/cgs_div.sv =====
module cgs_div
    import cgs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_res o_res
);

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_W-1:0]    r_cnt;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_div;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_NUM_W-1:0] r_quot;

    logic [CNT_W:0]       trial;
    logic                 fits;
    logic [CNT_W:0]       diff;

    // One quotient bit per cycle, restoring
    assign trial = {r_rem, r_num[DIV_NUM_W-1]};
    assign fits  = (trial >= {1'b0, r_div});
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.rem_init;
            r_div  <= i_req.divisor;
            r_num  <= i_req.num;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            r_num  <= r_num << 1;
            r_quot <= {r_quot[DIV_NUM_W-2:0], fits};
        end
    end

    assign o_res.busy = r_busy;
    assign o_res.done = r_done;
    assign o_res.quot = r_quot;
    assign o_res.rem  = r_rem;

endmodule

// ===== hdl/cgs_fade_mem.sv =====
module cgs_fade_mem
    import cgs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_fade_req        i_req,
    output logic [CNT_W-1:0] o_cnt
);

    logic [CNT_W-1:0]        r_mem [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] r_vld;
    logic [CNT_W-1:0]        r_rd_data;
    logic                    r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    // Entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.addr];
            end
        end
    end

    assign o_cnt = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== hdl/cgs_mix.sv =====
module cgs_mix
    import cgs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mix_req                i_req,
    output logic signed [MIX_W-1:0] o_mixed
);

    logic signed [ACC_W-1:0] r_acc [MAX_GROUP_SIZE];
    logic signed [32:0]      r_prod;

    logic signed [15:0]      smp;
    logic signed [16:0]      gain_s;
    logic signed [33:0]      rounded;
    logic signed [33:0]      shifted;
    logic [16:0]             contrib;
    logic signed [ACC_W:0]   sum;
    logic signed [ACC_W-1:0] acc_rd;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
        if (v > 25'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -25'sd8388608) begin
            return 24'sh800000;
        end
        return v[ACC_W-1:0];
    endfunction

    function automatic logic signed [MIX_W-1:0] sat_mix(input logic signed [ACC_W-1:0] v);
        if (v > 24'sd131071) begin
            return 18'sh1FFFF;
        end else if (v < -24'sd131072) begin
            return 18'sh20000;
        end
        return v[MIX_W-1:0];
    endfunction

    assign smp     = i_req.sample;
    assign gain_s  = {1'b0, i_req.gain};
    assign acc_rd  = r_acc[i_req.idx];

    // Round half up, then floor by 2^15
    assign rounded = {r_prod[32], r_prod} + 34'sd16384;
    assign shifted = rounded >>> 15;
    assign contrib = shifted[16:0];
    assign sum     = {acc_rd[ACC_W-1], acc_rd} + {{(ACC_W-16){contrib[16]}}, contrib};

    always_ff @(posedge i_clk) begin
        if (i_req.mul_en) begin
            r_prod <= smp * gain_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clr) begin
            for (int i = 0; i < MAX_GROUP_SIZE; i++) begin
                r_acc[i] <= '0;
            end
        end else if (i_req.acc_en) begin
            r_acc[i_req.idx] <= sat_acc(sum);
        end
    end

    assign o_mixed = sat_mix(acc_rd);

endmodule

// ===== hdl/crossfade_group_selector.sv =====
// Crossfading group selector.
// Input channel i_in carries select requests (kind 0) and channel sample
// requests (kind 1). Output channel o_out carries one mixed result per output
// channel after the sample marked frame_end; the last one has last set.
// Configuration is written through i_cfg_wr_en / i_cfg_idx / i_cfg_data; the
// user must do so only while the block is idle, as the block does not enforce it.
// Sequence: a select request is taken in the idle state. A sample is accepted,
// then its channel is divided by the group size on the shared restoring divider,
// one bit per cycle, to find its group and lane, then it is multiplied and
// accumulated. A group head also reads and writes back its fade count and, while
// fading, divides that count by the fade length on the same divider to find the
// gain index. A channel past the last skips the multiply and accumulate.
// At frame end one result leaves per cycle through an output register while the
// receiver keeps up; a new request is accepted while the final result still
// waits. A stalled receiver holds the emit sequence.
// Reset clears all fade counts, accumulators, the selection and the gain,
// and sets every configuration register to 1.
`include "crossfade_group_selector_assert.svh"

module crossfade_group_selector
    import cgs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    cgs_in_if.sink      i_in,
    cgs_out_if.source   o_out,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [3:0]          r_gs;
    logic [6:0]          r_ch_cnt;
    logic [CNT_W-1:0]    r_fade;

    logic [6:0]          r_sel, n_sel;
    logic [GAIN_W-1:0]   r_gain, n_gain;
    logic [CH_W-1:0]     r_ch, n_ch;
    logic [15:0]         r_sample, n_sample;
    logic                r_fend, n_fend;
    logic [GS_IDX_W-1:0] r_rmd, n_rmd;
    logic [CH_W-1:0]     r_grp, n_grp;
    logic [GS_IDX_W-1:0] r_k, n_k;

    logic                r_out_valid, n_out_valid;
    logic [2:0]          r_out_ch, n_out_ch;
    logic [MIX_W-1:0]    r_out_mixed, n_out_mixed;
    logic                r_out_last, n_out_last;

    logic [3:0]          gs_eff;
    logic [CNT_W-1:0]    fade_eff;
    logic [CNT_W-1:0]    cnt_rd;
    logic [CNT_W-1:0]    cnt_new;
    logic                active;
    logic                emit_load;
    logic                emit_last;
    logic signed [MIX_W-1:0] mix_rd;

    t_div_req  div_req;
    t_div_res  div_res;
    t_fade_req fade_req;
    t_mix_req  mix_req;

    cgs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_res   (div_res)
    );

    cgs_fade_mem u_fade_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fade_req),
        .o_cnt   (cnt_rd)
    );

    cgs_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mix_req),
        .o_mixed (mix_rd)
    );

    assign gs_eff   = (r_gs == 4'd0) ? 4'd1 :
                      (r_gs > 4'(MAX_GROUP_SIZE)) ? 4'(MAX_GROUP_SIZE) : r_gs;
    assign fade_eff = (r_fade == '0) ? CNT_W'(1) : r_fade;

    assign active   = (r_sel != 7'd0) && ((r_sel - 7'd1) == {1'b0, r_grp});

    always_comb begin
        cnt_new = cnt_rd;
        if (active && (cnt_rd < fade_eff)) begin
            cnt_new = cnt_rd + CNT_W'(1);
        end else if (!active && (cnt_rd != '0)) begin
            cnt_new = cnt_rd - CNT_W'(1);
        end
    end

    assign i_in.ready  = (r_state == ST_IDLE);
    assign emit_load   = (r_state == ST_EMIT) && (!r_out_valid || o_out.ready);
    assign emit_last   = ({1'b0, r_k} == (gs_eff - 4'd1));

    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        n_gain      = r_gain;
        n_ch        = r_ch;
        n_sample    = r_sample;
        n_fend      = r_fend;
        n_rmd       = r_rmd;
        n_grp       = r_grp;
        n_k         = r_k;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_ch    = r_out_ch;
        n_out_mixed = r_out_mixed;
        n_out_last  = r_out_last;

        div_req          = '0;
        fade_req         = '0;
        fade_req.addr    = r_ch;
        fade_req.wdata   = cnt_new;
        mix_req          = '0;
        mix_req.idx      = (r_state == ST_EMIT) ? r_k : r_rmd;
        mix_req.sample   = r_sample;
        mix_req.gain     = r_gain;

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.kind == KIND_SELECT) begin
                        n_sel = i_in.select_group;
                    end else begin
                        n_ch             = i_in.channel;
                        n_sample         = i_in.sample;
                        n_fend           = i_in.frame_end;
                        // channel / group size: quotient is the group, remainder the lane
                        div_req.start    = 1'b1;
                        div_req.rem_init = '0;
                        div_req.num      = DIV_NUM_W'(i_in.channel) << (DIV_NUM_W - CH_W);
                        div_req.steps    = STEP_W'(CH_W);
                        div_req.divisor  = CNT_W'(gs_eff);
                        n_state          = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                if (div_res.done) begin
                    n_rmd = div_res.rem[GS_IDX_W-1:0];
                    n_grp = div_res.quot[CH_W-1:0];
                    n_k   = '0;
                    if ({1'b0, r_ch} < r_ch_cnt) begin
                        if (div_res.rem == '0) begin
                            fade_req.rd_en = 1'b1;
                            n_state        = ST_CNT;
                        end else begin
                            n_state = ST_MUL;
                        end
                    end else begin
                        n_state = r_fend ? ST_EMIT : ST_IDLE;
                    end
                end
            end
            ST_CNT: begin
                fade_req.wr_en = 1'b1;
                if (cnt_new == '0) begin
                    n_gain  = '0;
                    n_state = ST_MUL;
                end else if (cnt_new < fade_eff) begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = cnt_new;
                    div_req.num      = '0;
                    div_req.steps    = STEP_W'(SINE_IDX_W);
                    div_req.divisor  = fade_eff;
                    n_state          = ST_DIV;
                end else begin
                    n_gain  = GAIN_ONE;
                    n_state = ST_MUL;
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    n_gain  = SINE_TAB[div_res.quot[SINE_IDX_W-1:0]];
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                mix_req.mul_en = 1'b1;
                n_state        = ST_ACC;
            end
            ST_ACC: begin
                mix_req.acc_en = 1'b1;
                n_k            = '0;
                n_state        = r_fend ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (emit_load) begin
                    n_out_valid = 1'b1;
                    n_out_ch    = 3'(r_k);
                    n_out_mixed = mix_rd;
                    n_out_last  = emit_last;
                    if (emit_last) begin
                        mix_req.clr = 1'b1;
                        n_gain      = '0;
                        n_state     = ST_IDLE;
                    end else begin
                        n_k = r_k + GS_IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel       <= '0;
            r_gain      <= '0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            r_sel       <= n_sel;
            r_gain      <= n_gain;
            r_out_valid <= n_out_valid;
            r_k         <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch        <= n_ch;
        r_sample    <= n_sample;
        r_fend      <= n_fend;
        r_rmd       <= n_rmd;
        r_grp       <= n_grp;
        r_out_ch    <= n_out_ch;
        r_out_mixed <= n_out_mixed;
        r_out_last  <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gs     <= 4'd1;
            r_ch_cnt <= 7'd1;
            r_fade   <= CNT_W'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_GROUP_SIZE:    r_gs     <= i_cfg_data[3:0];
                CFG_CHANNEL_COUNT: r_ch_cnt <= i_cfg_data[6:0];
                CFG_FADE_SAMPLES:  r_fade   <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_channel = r_out_ch;
    assign o_out.mixed       = r_out_mixed;
    assign o_out.last        = r_out_last;

    `CGS_ASSERT_HOLDS(a_emit_idx, (r_state != ST_EMIT) || (4'(r_k) < gs_eff), "emit index too high")
    `CGS_ASSERT_HOLDS(a_gain_range, r_gain <= GAIN_ONE, "gain above unity")
    `CGS_ASSERT_HOLDS(a_div_free, !(div_req.start && div_res.busy), "divider started while busy")
    `CGS_ASSERT_NEXT(a_emit_done, emit_load && emit_last, r_state == ST_IDLE && r_gain == '0, "not idle")

endmodule
